### rtl/cse_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package cse_pkg;

  localparam int KEY_W       = 8;
  localparam int PAYLOAD_W   = 32;
  localparam int KEY_COUNT_W = 9;
  localparam int KEY_LIMIT   = 256;

  localparam logic [KEY_COUNT_W-1:0] KEY_COUNT_RESET = 9'd256;

endpackage

`default_nettype wire

### rtl/counting_sort_engine_core.sv
// Loading: one element per cycle, elem_stall low throughout the load.
// After the transfer that carries elem_last: a drain state, a prefix sum over nk entries
// of the tally memory (nk = effective key count), scatter of the stored elements
// and emission of the stored elements, one element per cycle unless out_stall.
// Tally memory, loaded store and sorted store have registered reads and a separate write port.
// rst (synchronous) returns to loading, empties the set and sets key_count to 256.
`timescale 1ns / 1ps
`default_nettype none

module counting_sort_engine_core #(
  parameter int MAX_ITEMS    = 64,
  parameter int KEY_SLOTS    = 256,
  parameter int PAYLOAD_BITS = 32
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_wr_en,
  input  logic [cse_pkg::KEY_COUNT_W-1:0]   cfg_wr_data,
  input  logic                              elem_valid,
  output logic                              elem_stall,
  input  logic [cse_pkg::KEY_W-1:0]         elem_key,
  input  logic [cse_pkg::PAYLOAD_W-1:0]     elem_payload,
  input  logic                              elem_last,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic [cse_pkg::KEY_W-1:0]         out_key,
  output logic [cse_pkg::PAYLOAD_W-1:0]     out_payload,
  output logic                              out_last
);

  import cse_pkg::*;

  localparam int TS  = (KEY_SLOTS < KEY_LIMIT) ? KEY_SLOTS : KEY_LIMIT;
  localparam int TAW = $clog2(TS);
  localparam int CW  = $clog2(MAX_ITEMS + 1);
  localparam int IW  = $clog2(MAX_ITEMS);
  localparam int PW  = (PAYLOAD_BITS < PAYLOAD_W) ? PAYLOAD_BITS : PAYLOAD_W;
  localparam int SW  = KEY_W + PW;

  typedef enum logic [2:0] {
    ST_LOAD,
    ST_DRAIN,
    ST_PREFIX,
    ST_SCATTER,
    ST_EMIT
  } state_t;

  state_t                   state;
  logic [KEY_COUNT_W-1:0]   key_count;
  logic [KEY_COUNT_W-1:0]   nk;
  logic [KEY_W-1:0]         key_cl;
  logic [CW-1:0]            loaded_total;

  logic                     accept;
  logic                     store_ok;
  logic                     ld_we;
  logic                     ld_re;
  logic                     s_re;
  logic                     out_load;
  logic                     set_done;

  logic                     s1_valid;
  logic [TAW-1:0]           s1_key;

  logic [CW-1:0]            tally_mem [TS];
  logic [TS-1:0]            tally_vld;
  logic [CW-1:0]            t_rdata;
  logic                     t_rvalid;
  logic                     fwd_hit;
  logic [CW-1:0]            fwd_val;
  logic                     t_re;
  logic [TAW-1:0]           t_raddr;
  logic                     t_we;
  logic [TAW-1:0]           t_waddr;
  logic [CW-1:0]            t_wdata;
  logic [CW-1:0]            t_base;

  logic [KEY_COUNT_W-1:0]   p_idx;
  logic                     p1_valid;
  logic [TAW-1:0]           p1_idx;
  logic [CW-1:0]            pos;

  logic [SW-1:0]            ld_mem [MAX_ITEMS];
  logic [SW-1:0]            ld_rdata;
  logic [KEY_W-1:0]         b_key;
  logic [CW-1:0]            sc_idx;
  logic                     b_valid;
  logic                     c_valid;
  logic [SW-1:0]            c_elem;
  logic [TAW-1:0]           c_taddr;

  logic [SW-1:0]            srt_mem [MAX_ITEMS];
  logic [SW-1:0]            srt_rdata;
  logic [CW-1:0]            em_idx;
  logic                     s_rvalid;
  logic                     s_last;

  always_comb begin
    if (key_count == '0) begin
      nk = KEY_COUNT_W'(1);
    end else if (key_count > KEY_COUNT_W'(TS)) begin
      nk = KEY_COUNT_W'(TS);
    end else begin
      nk = key_count;
    end
  end

  assign key_cl     = (KEY_COUNT_W'(elem_key) >= nk) ? KEY_W'(nk - KEY_COUNT_W'(1)) : elem_key;
  assign elem_stall = (state != ST_LOAD);
  assign accept     = elem_valid && !elem_stall;
  assign store_ok   = (loaded_total < CW'(MAX_ITEMS));
  assign ld_we      = accept && store_ok;
  assign ld_re      = (state == ST_SCATTER) && (sc_idx < loaded_total);
  assign out_load   = s_rvalid && (!out_valid || !out_stall);
  assign s_re       = (state == ST_EMIT) && (em_idx < loaded_total) && (!s_rvalid || out_load);
  assign set_done   = (state == ST_EMIT) && (em_idx == loaded_total) && !s_rvalid;
  assign b_key      = ld_rdata[SW-1 -: KEY_W];
  assign t_base     = fwd_hit ? fwd_val : (t_rvalid ? t_rdata : '0);

  always_comb begin
    t_re    = 1'b0;
    t_raddr = '0;
    t_we    = 1'b0;
    t_waddr = '0;
    t_wdata = '0;
    case (state)
      ST_LOAD, ST_DRAIN: begin
        t_re    = ld_we;
        t_raddr = key_cl[TAW-1:0];
        t_we    = s1_valid;
        t_waddr = s1_key;
        t_wdata = t_base + CW'(1);
      end
      ST_PREFIX: begin
        t_re    = (p_idx < nk);
        t_raddr = p_idx[TAW-1:0];
        t_we    = p1_valid;
        t_waddr = p1_idx;
        t_wdata = pos;
      end
      ST_SCATTER: begin
        t_re    = b_valid;
        t_raddr = b_key[TAW-1:0];
        t_we    = c_valid;
        t_waddr = c_taddr;
        t_wdata = t_base + CW'(1);
      end
      default: begin
        t_re = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (t_we) begin
      tally_mem[t_waddr] <= t_wdata;
    end
    if (t_re) begin
      t_rdata <= tally_mem[t_raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (ld_we) begin
      ld_mem[loaded_total[IW-1:0]] <= {key_cl, elem_payload[PW-1:0]};
    end
    if (ld_re) begin
      ld_rdata <= ld_mem[sc_idx[IW-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (c_valid) begin
      srt_mem[t_base[IW-1:0]] <= c_elem;
    end
    if (s_re) begin
      srt_rdata <= srt_mem[em_idx[IW-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tally_vld <= '0;
      t_rvalid  <= 1'b0;
      fwd_hit   <= 1'b0;
    end else begin
      if (set_done) begin
        tally_vld <= '0;
      end else if (t_we) begin
        tally_vld[t_waddr] <= 1'b1;
      end
      if (t_re) begin
        t_rvalid <= tally_vld[t_raddr];
      end
      fwd_hit <= t_re && t_we && (t_raddr == t_waddr);
    end
  end

  always_ff @(posedge clk) begin
    fwd_val <= t_wdata;
    if (ld_we) begin
      s1_key <= key_cl[TAW-1:0];
    end
    p1_idx <= p_idx[TAW-1:0];
    if (b_valid) begin
      c_elem  <= ld_rdata;
      c_taddr <= b_key[TAW-1:0];
    end
    if (s_re) begin
      s_last <= (em_idx == loaded_total - CW'(1));
    end
    if (out_load) begin
      out_key     <= srt_rdata[SW-1 -: KEY_W];
      out_payload <= PAYLOAD_W'(srt_rdata[PW-1:0]);
      out_last    <= s_last;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_LOAD;
      key_count    <= KEY_COUNT_RESET;
      loaded_total <= '0;
      s1_valid     <= 1'b0;
      p_idx        <= '0;
      p1_valid     <= 1'b0;
      pos          <= '0;
      sc_idx       <= '0;
      b_valid      <= 1'b0;
      c_valid      <= 1'b0;
      em_idx       <= '0;
      s_rvalid     <= 1'b0;
      out_valid    <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        key_count <= cfg_wr_data;
      end
      s1_valid <= ld_we;
      p1_valid <= (state == ST_PREFIX) && t_re;
      b_valid  <= ld_re;
      c_valid  <= b_valid;
      if (ld_we) begin
        loaded_total <= loaded_total + CW'(1);
      end
      if (s_re) begin
        s_rvalid <= 1'b1;
      end else if (out_load) begin
        s_rvalid <= 1'b0;
      end
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
      case (state)
        ST_LOAD: begin
          if (accept && elem_last) begin
            state <= ST_DRAIN;
          end
        end
        ST_DRAIN: begin
          state <= ST_PREFIX;
          p_idx <= '0;
          pos   <= '0;
        end
        ST_PREFIX: begin
          if (t_re) begin
            p_idx <= p_idx + KEY_COUNT_W'(1);
          end
          if (p1_valid) begin
            pos <= pos + t_base;
          end
          if (!t_re && !p1_valid) begin
            state  <= ST_SCATTER;
            sc_idx <= '0;
          end
        end
        ST_SCATTER: begin
          if (ld_re) begin
            sc_idx <= sc_idx + CW'(1);
          end
          if (!ld_re && !b_valid && !c_valid) begin
            state  <= ST_EMIT;
            em_idx <= '0;
          end
        end
        ST_EMIT: begin
          if (s_re) begin
            em_idx <= em_idx + CW'(1);
          end
          if (set_done) begin
            state        <= ST_LOAD;
            loaded_total <= '0;
          end
        end
        default: begin
          state <= ST_LOAD;
        end
      endcase
    end
  end

  a_total_bound: assert property (@(posedge clk) disable iff (rst)
    loaded_total <= CW'(MAX_ITEMS))
    else $error("element count beyond store depth");

  a_scatter_dst: assert property (@(posedge clk) disable iff (rst)
    c_valid |-> (t_base < loaded_total))
    else $error("scatter destination outside the set");

  a_prefix_sum: assert property (@(posedge clk) disable iff (rst)
    (state == ST_PREFIX) |-> (pos <= loaded_total))
    else $error("prefix sum exceeds element count");

  a_fwd_phase: assert property (@(posedge clk) disable iff (rst)
    fwd_hit |-> (state == ST_LOAD || state == ST_DRAIN || state == ST_SCATTER))
    else $error("tally forward outside count or scatter");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_stall) |=> (out_valid && $stable(out_key) &&
                                  $stable(out_payload) && $stable(out_last)))
    else $error("stalled result changed");

endmodule

`default_nettype wire
